FILE: rtl/core/shl_pkg.sv
package shl_pkg;

  localparam int MAX_VALUE_LEN_DEF = 255;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [15:0] TOKEN_LIMIT_RST = 16'd256;
  localparam logic [15:0] TOKEN_COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_COMMENT  = 3'd1,
    MODE_WORD     = 3'd2,
    MODE_NUMBER   = 3'd3,
    MODE_STRING   = 3'd4,
    MODE_STR_TAIL = 3'd5,
    MODE_HELD     = 3'd6
  } lex_mode_t;

  typedef enum logic [1:0] {
    HELD_PIPE = 2'd0,
    HELD_AMP  = 2'd1,
    HELD_GT   = 2'd2,
    HELD_LT   = 2'd3
  } held_op_t;

  typedef enum logic [4:0] {
    KIND_WORD    = 5'd0,
    KIND_STRING  = 5'd1,
    KIND_NUMBER  = 5'd2,
    KIND_ANDOR   = 5'd3,
    KIND_SEMI    = 5'd4,
    KIND_NEWLINE = 5'd5,
    KIND_PIPE    = 5'd6,
    KIND_AMP     = 5'd7,
    KIND_GT      = 5'd8,
    KIND_LT      = 5'd9,
    KIND_DGT     = 5'd10,
    KIND_DLT     = 5'd11,
    KIND_AMP_GT  = 5'd12,
    KIND_EQUALS  = 5'd13,
    KIND_LPAREN  = 5'd14,
    KIND_RPAREN  = 5'd15,
    KIND_LBRACE  = 5'd16,
    KIND_RBRACE  = 5'd17,
    KIND_DOLLAR  = 5'd18,
    KIND_EOF     = 5'd19
  } tok_kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] value;
    logic       present;
    logic       done;
  } shl_result_t;

  // All results caused by one text byte; second is valid only with pair.
  typedef struct packed {
    shl_result_t first;
    shl_result_t second;
    logic        pair;
  } shl_step_t;

  // Handshake between the queue head and the output stage.
  typedef struct packed {
    logic      valid;
    shl_step_t step;
  } shl_head_t;

  function automatic shl_result_t mk_result(tok_kind_t k, logic [7:0] v, logic p, logic d);
    shl_result_t r;
    r.kind    = k;
    r.value   = v;
    r.present = p;
    r.done    = d;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic word_stop(logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_SEMI) || (c == CH_PIPE) || (c == CH_AMP) || (c == CH_GT) ||
           (c == CH_LT) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic [7:0] held_char(held_op_t h);
    logic [7:0] ch;
    unique case (h)
      HELD_PIPE: ch = CH_PIPE;
      HELD_AMP:  ch = CH_AMP;
      HELD_GT:   ch = CH_GT;
      HELD_LT:   ch = CH_LT;
      default:   ch = CH_PIPE;
    endcase
    return ch;
  endfunction

  function automatic tok_kind_t held_kind(held_op_t h);
    tok_kind_t k;
    unique case (h)
      HELD_PIPE: k = KIND_PIPE;
      HELD_AMP:  k = KIND_AMP;
      HELD_GT:   k = KIND_GT;
      HELD_LT:   k = KIND_LT;
      default:   k = KIND_PIPE;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/shl_front.sv
module shl_front #(
  parameter int MAX_VALUE_LEN = shl_pkg::MAX_VALUE_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        text_byte,
  input  logic [15:0]       token_limit,
  output logic              push,
  output shl_pkg::shl_step_t step
);
  import shl_pkg::*;

  localparam int LEN_W = $clog2(MAX_VALUE_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_VALUE_LEN);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  lex_mode_t        mode_r, mode_nxt;
  logic             quote_r, quote_nxt;
  held_op_t         held_r, held_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      cnt_r, cnt_nxt;

  // State after the current mode has handled the byte.
  lex_mode_t        m1;
  logic             q1;
  held_op_t         h1;
  logic [LEN_W-1:0] len1;
  logic [15:0]      cnt1;
  logic             has_r0, has_r1, do_idle;
  shl_result_t      r0, r1;

  // State after the byte has been taken again as a token start.
  lex_mode_t        m2;
  logic             q2;
  held_op_t         h2;
  logic [LEN_W-1:0] len2;
  logic [15:0]      cnt2;
  logic             idle_emit;
  shl_result_t      idle_res;

  logic [7:0]       quote_ch;
  logic [LEN_W-1:0] len_inc;
  logic [15:0]      cnt_inc0;

  assign quote_ch = quote_r ? CH_SQUOTE : CH_DQUOTE;
  assign len_inc  = len_r + LEN_ONE;
  assign cnt_inc0 = (cnt_r != TOKEN_COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;

  always_comb begin
    logic      close1, add1, pair;
    tok_kind_t ck, ak, pk;
    close1  = 1'b0;
    add1    = 1'b0;
    pair    = 1'b0;
    ck      = KIND_WORD;
    ak      = KIND_WORD;
    pk      = KIND_ANDOR;
    m1      = mode_r;
    q1      = quote_r;
    h1      = held_r;
    len1    = len_r;
    cnt1    = cnt_r;
    has_r0  = 1'b0;
    has_r1  = 1'b0;
    do_idle = 1'b0;
    r0      = '0;
    r1      = '0;
    unique case (mode_r)
      MODE_COMMENT: begin
        if ((text_byte == CH_LF) || (text_byte == CH_NUL)) begin
          m1      = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_WORD: begin
        if (word_stop(text_byte)) begin
          close1  = 1'b1;
          ck      = KIND_WORD;
          do_idle = 1'b1;
        end else begin
          add1 = 1'b1;
          ak   = KIND_WORD;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(text_byte)) begin
          add1 = 1'b1;
          ak   = KIND_NUMBER;
        end else begin
          close1  = 1'b1;
          ck      = KIND_NUMBER;
          do_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        if (text_byte == CH_NUL) begin
          close1  = 1'b1;
          ck      = KIND_STRING;
          do_idle = 1'b1;
        end else if (text_byte == quote_ch) begin
          close1 = 1'b1;
          ck     = KIND_STRING;
        end else begin
          add1 = 1'b1;
          ak   = KIND_STRING;
        end
      end
      MODE_STR_TAIL: begin
        // A cut string swallows its closing quote when it follows at once.
        m1      = MODE_IDLE;
        do_idle = (text_byte != quote_ch);
      end
      MODE_HELD: begin
        priority if ((held_r == HELD_PIPE) && (text_byte == CH_PIPE)) begin
          pair = 1'b1;
          pk   = KIND_ANDOR;
        end else if ((held_r == HELD_AMP) && (text_byte == CH_AMP)) begin
          pair = 1'b1;
          pk   = KIND_ANDOR;
        end else if ((held_r == HELD_AMP) && (text_byte == CH_GT)) begin
          pair = 1'b1;
          pk   = KIND_AMP_GT;
        end else if ((held_r == HELD_GT) && (text_byte == CH_GT)) begin
          pair = 1'b1;
          pk   = KIND_DGT;
        end else if ((held_r == HELD_LT) && (text_byte == CH_LT)) begin
          pair = 1'b1;
          pk   = KIND_DLT;
        end else begin
          pair = 1'b0;
        end
        m1     = MODE_IDLE;
        h1     = HELD_PIPE;
        cnt1   = cnt_inc0;
        len1   = '0;
        has_r0 = 1'b1;
        if (pair) begin
          has_r1 = 1'b1;
          r0     = mk_result(pk, held_char(held_r), 1'b1, 1'b0);
          r1     = mk_result(pk, text_byte, 1'b1, 1'b1);
        end else begin
          r0      = mk_result(held_kind(held_r), held_char(held_r), 1'b1, 1'b1);
          do_idle = 1'b1;
        end
      end
      default: begin
        m1      = MODE_IDLE;
        do_idle = 1'b1;
      end
    endcase

    if (close1) begin
      has_r0 = 1'b1;
      r0     = mk_result(ck, 8'h00, 1'b0, 1'b1);
      cnt1   = cnt_inc0;
      len1   = '0;
      m1     = MODE_IDLE;
    end
    if (add1) begin
      has_r0 = 1'b1;
      if (len_inc >= LEN_MAX) begin
        r0   = mk_result(ak, text_byte, 1'b1, 1'b1);
        cnt1 = cnt_inc0;
        len1 = '0;
        m1   = (mode_r == MODE_STRING) ? MODE_STR_TAIL : MODE_IDLE;
      end else begin
        r0   = mk_result(ak, text_byte, 1'b1, 1'b0);
        len1 = len_inc;
      end
    end
  end

  always_comb begin
    logic        sgl;
    tok_kind_t   sk;
    logic [15:0] cnt_inc1;
    sgl       = 1'b0;
    sk        = KIND_SEMI;
    cnt_inc1  = (cnt1 != TOKEN_COUNT_MAX) ? cnt1 + 16'd1 : cnt1;
    m2        = MODE_IDLE;
    q2        = q1;
    h2        = h1;
    len2      = len1;
    cnt2      = cnt1;
    idle_emit = 1'b0;
    idle_res  = '0;
    if (text_byte == CH_NUL) begin
      idle_emit = (cnt1 < token_limit);
      idle_res  = mk_result(KIND_EOF, 8'h00, 1'b0, 1'b1);
      q2        = 1'b0;
      h2        = HELD_PIPE;
      len2      = '0;
      cnt2      = '0;
    end else if (cnt1 < token_limit) begin
      unique case (text_byte)
        CH_SPACE, CH_TAB: ;
        CH_HASH:   m2 = MODE_COMMENT;
        CH_DQUOTE: begin
          m2   = MODE_STRING;
          q2   = 1'b0;
          len2 = '0;
        end
        CH_SQUOTE: begin
          m2   = MODE_STRING;
          q2   = 1'b1;
          len2 = '0;
        end
        CH_LF:     begin sgl = 1'b1; sk = KIND_NEWLINE; end
        CH_SEMI:   begin sgl = 1'b1; sk = KIND_SEMI;    end
        CH_LPAREN: begin sgl = 1'b1; sk = KIND_LPAREN;  end
        CH_RPAREN: begin sgl = 1'b1; sk = KIND_RPAREN;  end
        CH_LBRACE: begin sgl = 1'b1; sk = KIND_LBRACE;  end
        CH_RBRACE: begin sgl = 1'b1; sk = KIND_RBRACE;  end
        CH_DOLLAR: begin sgl = 1'b1; sk = KIND_DOLLAR;  end
        CH_EQ:     begin sgl = 1'b1; sk = KIND_EQUALS;  end
        CH_PIPE:   begin m2 = MODE_HELD; h2 = HELD_PIPE; end
        CH_AMP:    begin m2 = MODE_HELD; h2 = HELD_AMP;  end
        CH_GT:     begin m2 = MODE_HELD; h2 = HELD_GT;   end
        CH_LT:     begin m2 = MODE_HELD; h2 = HELD_LT;   end
        default: begin
          idle_emit = 1'b1;
          sk        = is_digit(text_byte) ? KIND_NUMBER : KIND_WORD;
          if (LEN_ONE >= LEN_MAX) begin
            idle_res = mk_result(sk, text_byte, 1'b1, 1'b1);
            cnt2     = cnt_inc1;
            len2     = '0;
          end else begin
            idle_res = mk_result(sk, text_byte, 1'b1, 1'b0);
            len2     = LEN_ONE;
            m2       = is_digit(text_byte) ? MODE_NUMBER : MODE_WORD;
          end
        end
      endcase
      if (sgl) begin
        idle_emit = 1'b1;
        idle_res  = mk_result(sk, text_byte, 1'b1, 1'b1);
        cnt2      = cnt_inc1;
        len2      = '0;
      end
    end
  end

  always_comb begin
    logic extra;
    extra       = do_idle && idle_emit;
    push        = accept && (has_r0 || extra);
    step.first  = has_r0 ? r0 : idle_res;
    step.second = has_r1 ? r1 : idle_res;
    step.pair   = has_r1 || (has_r0 && extra);
    mode_nxt    = do_idle ? m2 : m1;
    quote_nxt   = do_idle ? q2 : q1;
    held_nxt    = do_idle ? h2 : h1;
    len_nxt     = do_idle ? len2 : len1;
    cnt_nxt     = do_idle ? cnt2 : cnt1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      quote_r <= 1'b0;
      held_r  <= HELD_PIPE;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      held_r  <= held_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // A token value is closed the moment it reaches its length limit.
  a_len_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < LEN_MAX)
    else $error("token value length reached limit without closing");

endmodule

FILE: rtl/core/shl_queue.sv
module shl_queue #(
  parameter int DEPTH = shl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  shl_pkg::shl_step_t push_step,
  output logic               full,
  output shl_pkg::shl_head_t head,
  input  logic               pop
);
  import shl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  shl_step_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full       = (cnt_r == CNT_FULL);
  assign head.valid = (cnt_r != '0);
  assign head.step  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("step queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("step queue read while empty");

endmodule

FILE: rtl/core/shl_back.sv
module shl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  shl_pkg::shl_head_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [6:0]         out_tuser
);
  import shl_pkg::*;

  logic        valid_r;
  logic        sub_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic [6:0]  user_r;
  logic        load, step_end;
  shl_result_t sel;

  assign load     = head.valid && (!valid_r || out_tready);
  assign sel      = sub_r ? head.step.second : head.step.first;
  assign step_end = sub_r || !head.step.pair;
  assign pop      = load && step_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= !step_end;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= sel.value;
      last_r <= sel.done;
      user_r <= {step_end, sel.present, sel.kind};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = user_r;

  // The second result of a step is only pending while that step is still at the head.
  a_sub_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (head.valid && head.step.pair))
    else $error("second result selected without a two-result step");

endmodule

FILE: rtl/core/shell_command_lexer.sv
// Results of a text byte are written into the step queue as the byte is accepted and
// then pass through the output register; a second result from the byte follows the first.
// Throughput: one text byte per cycle while each byte yields at most one result and
// out_tready stays high; a byte with two results holds its queue entry until both are loaded.
// A four-entry step queue lets input and output stall independently.
// Reset: synchronous, active low; clears lexer state and queue, token_limit returns to 256.
module shell_command_lexer #(
  parameter int MAX_VALUE_LEN = shl_pkg::MAX_VALUE_LEN_DEF,
  parameter int QUEUE_DEPTH   = shl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. in_tdata: [7:0] text_byte.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result stream. out_tdata: [7:0] value_byte. out_tlast: token_done.
  // out_tuser: [4:0] token_kind, [5] byte_present, [6] step_last.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic [6:0]  out_tuser,
  // Configuration port; token_limit lies at byte address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import shl_pkg::*;

  logic        [15:0] token_limit_r;
  logic               accept;
  logic               push;
  logic               full;
  logic               pop;
  shl_step_t          step;
  shl_head_t          head;

  // Word-aligned decode: address bit 2 selects the register, so anything at or above
  // byte address 4 lies beyond the single register and is ignored on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_limit_r <= TOKEN_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      token_limit_r <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, token_limit_r};

  // The front end takes a byte whenever the step queue has room; all results of the
  // byte (up to two) are queued in a single entry.
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  shl_front #(
    .MAX_VALUE_LEN (MAX_VALUE_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .text_byte   (in_tdata),
    .token_limit (token_limit_r),
    .push        (push),
    .step        (step)
  );

  shl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_step (step),
    .full      (full),
    .head      (head),
    .pop       (pop)
  );

  // The back end unpacks each queued step into one output transaction per result and
  // flags the final one of the step.
  shl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: tb/token_stream_checker.sv
`timescale 1ns / 1ps
module token_stream_checker #(
  parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic [6:0]  out_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned mismatches,
  output int unsigned pending
);
  import shl_pkg::*;

  localparam int unsigned RUN_MAX = MAX_VALUE_LEN_DEF;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] value;
    logic       present;
    logic       done;
    logic       last;
  } lexeme_t;

  lex_mode_t   mode;
  logic        quote_single;
  held_op_t    held;
  int unsigned run_len;
  logic [15:0] tok_count;
  logic [15:0] limit;
  lexeme_t     step_res[$];
  lexeme_t     tokens_due[$];
  lexeme_t     seen;
  lexeme_t     want;

  function automatic void put(tok_kind_t kind, logic [7:0] ch, logic present, logic done);
    lexeme_t r;
    r.kind    = kind;
    r.value   = ch;
    r.present = present;
    r.done    = done;
    r.last    = 1'b0;
    if (step_res.size() < 2) step_res.push_back(r);
  endfunction

  function automatic void close_token();
    if (tok_count != TOKEN_COUNT_MAX) tok_count++;
    run_len = 0;
  endfunction

  function automatic void whole_token(tok_kind_t kind, logic [7:0] ch);
    put(kind, ch, 1'b1, 1'b1);
    close_token();
  endfunction

  // A value that reaches the length cap closes on that character.
  function automatic void add_run_char(tok_kind_t kind, logic [7:0] ch);
    run_len++;
    if (run_len >= RUN_MAX) begin
      put(kind, ch, 1'b1, 1'b1);
      close_token();
      mode = (mode == MODE_STRING) ? MODE_STR_TAIL : MODE_IDLE;
    end else begin
      put(kind, ch, 1'b1, 1'b0);
    end
  endfunction

  function automatic void close_run(tok_kind_t kind);
    put(kind, 8'h00, 1'b0, 1'b1);
    close_token();
    mode = MODE_IDLE;
  endfunction

  function automatic void clear_text();
    mode         = MODE_IDLE;
    quote_single = 1'b0;
    held         = HELD_PIPE;
    run_len      = 0;
    tok_count    = '0;
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic breaks_word(logic [7:0] c);
    case (c)
      CH_NUL, CH_SPACE, CH_TAB, CH_LF, CH_SEMI, CH_PIPE, CH_AMP, CH_GT, CH_LT,
      CH_LPAREN, CH_RPAREN: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] c);
    if (c == CH_NUL) begin
      if (tok_count < limit) put(KIND_EOF, 8'h00, 1'b0, 1'b1);
      clear_text();
      return;
    end
    if (tok_count >= limit) return;
    case (c)
      CH_SPACE, CH_TAB: ;
      CH_HASH: mode = MODE_COMMENT;
      CH_DQUOTE, CH_SQUOTE: begin
        mode         = MODE_STRING;
        quote_single = (c == CH_SQUOTE);
        run_len      = 0;
      end
      CH_LF:     whole_token(KIND_NEWLINE, c);
      CH_SEMI:   whole_token(KIND_SEMI, c);
      CH_LPAREN: whole_token(KIND_LPAREN, c);
      CH_RPAREN: whole_token(KIND_RPAREN, c);
      CH_LBRACE: whole_token(KIND_LBRACE, c);
      CH_RBRACE: whole_token(KIND_RBRACE, c);
      CH_DOLLAR: whole_token(KIND_DOLLAR, c);
      CH_EQ:     whole_token(KIND_EQUALS, c);
      CH_PIPE: begin
        held = HELD_PIPE;
        mode = MODE_HELD;
      end
      CH_AMP: begin
        held = HELD_AMP;
        mode = MODE_HELD;
      end
      CH_GT: begin
        held = HELD_GT;
        mode = MODE_HELD;
      end
      CH_LT: begin
        held = HELD_LT;
        mode = MODE_HELD;
      end
      default: begin
        run_len = 0;
        if (digit_char(c)) begin
          mode = MODE_NUMBER;
          add_run_char(KIND_NUMBER, c);
        end else begin
          mode = MODE_WORD;
          add_run_char(KIND_WORD, c);
        end
      end
    endcase
  endfunction

  // The byte after | & > < either completes a two-character operator or
  // releases the held one as a single token and is then lexed on its own.
  function automatic void resolve_held(logic [7:0] c);
    logic [7:0] first;
    tok_kind_t  kind;
    tok_kind_t  lone;
    logic       pair;
    case (held)
      HELD_PIPE: begin
        first = CH_PIPE;
        lone  = KIND_PIPE;
      end
      HELD_AMP: begin
        first = CH_AMP;
        lone  = KIND_AMP;
      end
      HELD_GT: begin
        first = CH_GT;
        lone  = KIND_GT;
      end
      default: begin
        first = CH_LT;
        lone  = KIND_LT;
      end
    endcase
    pair = 1'b1;
    if (held == HELD_PIPE && c == CH_PIPE) kind = KIND_ANDOR;
    else if (held == HELD_AMP && c == CH_AMP) kind = KIND_ANDOR;
    else if (held == HELD_AMP && c == CH_GT) kind = KIND_AMP_GT;
    else if (held == HELD_GT && c == CH_GT) kind = KIND_DGT;
    else if (held == HELD_LT && c == CH_LT) kind = KIND_DLT;
    else begin
      kind = lone;
      pair = 1'b0;
    end
    mode = MODE_IDLE;
    held = HELD_PIPE;
    if (pair) begin
      put(kind, first, 1'b1, 1'b0);
      put(kind, c, 1'b1, 1'b1);
      close_token();
    end else begin
      whole_token(lone, first);
      start_token(c);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    logic [7:0] closer;
    lexeme_t    tail;
    closer = quote_single ? CH_SQUOTE : CH_DQUOTE;
    step_res.delete();
    case (mode)
      MODE_COMMENT: begin
        if (c == CH_LF || c == CH_NUL) begin
          mode = MODE_IDLE;
          start_token(c);
        end
      end
      MODE_WORD: begin
        if (breaks_word(c)) begin
          close_run(KIND_WORD);
          start_token(c);
        end else begin
          add_run_char(KIND_WORD, c);
        end
      end
      MODE_NUMBER: begin
        if (digit_char(c)) begin
          add_run_char(KIND_NUMBER, c);
        end else begin
          close_run(KIND_NUMBER);
          start_token(c);
        end
      end
      MODE_STRING: begin
        if (c == CH_NUL) begin
          close_run(KIND_STRING);
          start_token(c);
        end else if (c == closer) begin
          close_run(KIND_STRING);
        end else begin
          add_run_char(KIND_STRING, c);
        end
      end
      MODE_STR_TAIL: begin
        // A closing quote right after a cut string is swallowed.
        mode = MODE_IDLE;
        if (c != closer) start_token(c);
      end
      MODE_HELD: resolve_held(c);
      default: begin
        mode = MODE_IDLE;
        start_token(c);
      end
    endcase
    if (step_res.size() > 0) begin
      tail      = step_res[step_res.size() - 1];
      tail.last = 1'b1;
      step_res[step_res.size() - 1] = tail;
    end
    foreach (step_res[i]) tokens_due.push_back(step_res[i]);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      limit = TOKEN_LIMIT_RST;
      clear_text();
      tokens_due.delete();
      mismatches <= 0;
    end else begin
      if (in_tvalid && in_tready) lex_byte(in_tdata);
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) limit = pwdata[15:0];
      if (out_tvalid && out_tready) begin
        seen.kind    = tok_kind_t'(out_tuser[4:0]);
        seen.value   = out_tdata;
        seen.present = out_tuser[5];
        seen.done    = out_tlast;
        seen.last    = out_tuser[6];
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token result kind %0d value %02h present %0b done %0b last %0b",
                   $time, seen.kind, seen.value, seen.present, seen.done, seen.last);
          mismatches <= mismatches + 1;
        end else begin
          want = tokens_due.pop_front();
          if (seen !== want) begin
            $display("%0t: token result mismatch: expected kind %0d value %02h present %0b done %0b last %0b",
                     $time, want.kind, want.value, want.present, want.done, want.last);
            $display("%0t:                          actual kind %0d value %02h present %0b done %0b last %0b",
                     $time, seen.kind, seen.value, seen.present, seen.done, seen.last);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= tokens_due.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import shl_pkg::*;

  // token_limit is the only register and sits at byte address 0.
  localparam logic [2:0] TOKEN_LIMIT_ADDR = 3'd0;
  // A byte's first result passes the step queue and the output register before it can be
  // taken, so QUIET_CYCLES quiet cycles with nothing outstanding mean the lexer has settled.
  localparam int QUIET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tready = 1'b0;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = 3'd0;
  logic [31:0] pwdata     = 32'd0;

  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [6:0]  out_tuser;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned cycles         = 0;

  // Operator spellings the random text draws from, single and paired.
  string op_texts[16] = '{"&&", "||", "&>", ">>", "<<", "|", "&", ">", "<", ";",
                          "(", ")", "{", "}", "$", "="};

  always #2 clk = ~clk;

  shell_command_lexer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // The checker sees every transaction on all three ports and keeps its own
  // copy of the lexer state; it hands back the failure count and the number
  // of results still outstanding.
  token_stream_checker #(
    .LIMIT_ADDR (TOKEN_LIMIT_ADDR)
  ) i_token_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // The result side stalls at random according to the current phase. One
  // assignment per edge keeps the ready level free of same-step glitches.
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Hard stop in case the lexer hangs or drops results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one text byte and hold it until the transaction completes. An idle
  // gap may come first; either way tvalid gets exactly one update in the
  // step where the previous transaction finished.
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Characters that keep a word going: mostly letters, with '=' and '$'
  // embedded and some bytes from the upper half of the code range.
  function automatic logic [7:0] word_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return 8'h61 + 8'($urandom_range(25));
    else if (p < 86) return $urandom_range(1) ? CH_EQ : CH_DOLLAR;
    else return 8'($urandom_range(128, 255));
  endfunction

  // One lexical piece of script text. Most pieces are well formed so the
  // lexer goes deep into words, strings and operators; a share of raw noise
  // and unterminated strings keeps the odd paths busy.
  task automatic send_piece();
    int unsigned p;
    int unsigned n;
    logic [7:0]  q;
    logic [7:0]  c;
    p = $urandom_range(99);
    if (p < 22) begin
      send_byte(8'h61 + 8'($urandom_range(25)));
      n = $urandom_range(0, 7);
      repeat (n) send_byte(word_char());
    end else if (p < 32) begin
      n = $urandom_range(1, 6);
      repeat (n) send_byte(CH_ZERO + 8'($urandom_range(9)));
    end else if (p < 42) begin
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      send_byte(q);
      n = $urandom_range(0, 8);
      repeat (n) begin
        p = $urandom_range(99);
        if (p < 65) c = 8'h61 + 8'($urandom_range(25));
        else if (p < 75) c = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
        else if (p < 85) c = $urandom_range(1) ? CH_SPACE : CH_HASH;
        else c = 8'($urandom_range(128, 255));
        send_byte(c);
      end
      if ($urandom_range(9) != 0) send_byte(q);
    end else if (p < 60) begin
      send_string(op_texts[$urandom_range(15)]);
    end else if (p < 72) begin
      send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
    end else if (p < 78) begin
      send_byte(CH_HASH);
      n = $urandom_range(0, 6);
      repeat (n) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_LF);
        send_byte(c);
      end
      send_byte(CH_LF);
    end else if (p < 86) begin
      send_byte(CH_LF);
    end else begin
      send_byte(8'($urandom_range(1, 255)));
    end
  endtask

  // Random texts of a dozen pieces on average. The count may run out in the
  // middle of a text, which then carries over into the next setting.
  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      send_piece();
      if ($urandom_range(11) == 0) send_byte(CH_NUL);
    end
  endtask

  // Tokens long enough to hit the value length cap: a word and a number
  // that run past it, a string cut exactly at the cap whose closing quote
  // must then vanish, and a short string for contrast.
  task automatic send_long_runs();
    send_byte(8'h77);
    repeat (256) send_byte(word_char());
    send_byte(CH_SPACE);
    repeat (257) send_byte(CH_ZERO + 8'($urandom_range(9)));
    send_byte(CH_SEMI);
    send_byte(CH_DQUOTE);
    repeat (255) send_byte(8'h61 + 8'($urandom_range(25)));
    send_byte(CH_DQUOTE);
    send_byte(CH_SQUOTE);
    repeat (20) send_byte(8'h41 + 8'($urandom_range(25)));
    send_byte(CH_SQUOTE);
    send_byte(CH_NUL);
  endtask

  // Hold the input until every expected result has arrived and the lexer
  // has had time to absorb bytes that produce nothing.
  task automatic drain();
    int quiet;
    quiet = 0;
    in_tvalid <= 1'b0;
    while (quiet < QUIET_CYCLES) begin
      @(posedge clk);
      if (pending == 0) quiet++;
      else quiet = 0;
    end
  endtask

  // Setup and access cycle; the upper data bits carry junk that the
  // register must ignore.
  task automatic write_token_limit(input logic [15:0] value);
    logic [15:0] junk;
    junk = 16'($urandom);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TOKEN_LIMIT_ADDR;
    pwdata  <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text with the reset limit: a word, a tab, a number, &&, a quoted
    // string, >>, ||, a word with '=' inside, <<, every bracket, '$', '=',
    // ';', a pipe released by '&', &>, '<' released by a comment, a
    // newline after the comment, and a string left open at the end byte.
    send_string("x\t12&&'s'>>a||b=<<(){}$=;|&><#z\n\"u");
    send_byte(8'hFF);
    send_byte(CH_NUL);
    send_long_runs();
    run_random(120);

    // Highest limit, sender mostly idle.
    write_token_limit(16'hFFFF);
    send_idle_pct  = 79;
    recv_stall_pct = 0;
    run_random(120);

    // Very low limit, so most texts get cut off; receiver mostly stalled.
    write_token_limit(16'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 79;
    run_random(100);

    // Limit of zero: no token and no end token, only state that carries on.
    write_token_limit(16'd0);
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    run_random(40);

    write_token_limit(16'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(60);

    write_token_limit(16'($urandom_range(4, 40)));
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    run_random(130);

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
